// ----- src/wta_pkg.sv -----
// Package with the shared constants, types and codes of the competitive learning layer.
`default_nettype none

package wta_pkg;

    localparam int MAX_NEURONS = 4;
    localparam int MAX_INPUTS  = 64;
    localparam int WEIGHT_BITS = 16;

    localparam int NSEL_W  = 2;
    localparam int POS_W   = 6;
    localparam int ADDR_W  = NSEL_W + POS_W;
    localparam int DEPTH   = MAX_NEURONS * MAX_INPUTS;
    localparam int ACC_W   = 32;
    localparam int LR_W    = 16;
    localparam int NU_W    = 3;
    localparam int CNT_W   = 7;
    localparam int SHARE_W = 15;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    localparam int FRAC_ONE = 16384;

    localparam logic [LR_W-1:0]  LR_RESET      = 16'd6554;
    localparam logic [NU_W-1:0]  NEURONS_RESET = 3'd3;
    localparam logic [CNT_W-1:0] INPUTS_RESET  = 7'd35;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_LEARNING_RATE  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_NEURONS_IN_USE = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_INPUTS_IN_USE  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_ADD,
        ST_PICK,
        ST_DIV,
        ST_REPORT,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_WR
    } state_t;

    typedef struct packed {
        logic                   en;
        logic [ADDR_W-1:0]      addr;
        logic [WEIGHT_BITS-1:0] data;
    } wmem_wr_t;

endpackage

`default_nettype wire

// ----- src/wta_wmem.sv -----
// Weight memory with one write port and one registered read port.
`default_nettype none

module wta_wmem (
    input  wire logic                                 clk,
    input  wire wta_pkg::wmem_wr_t                    wr,
    input  wire logic [wta_pkg::ADDR_W-1:0]           raddr,
    output logic signed [wta_pkg::WEIGHT_BITS-1:0]    rdata
);
    import wta_pkg::*;

    logic [WEIGHT_BITS-1:0] mem [DEPTH];
    logic [WEIGHT_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = $signed(rdata_reg);

endmodule

`default_nettype wire

// ----- src/wta_div.sv -----
// Bit-serial restoring divider that forms the rounded share 16384 / ones count.
`default_nettype none

module wta_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [wta_pkg::CNT_W-1:0]         divisor,
    output logic                                   done,
    output logic [wta_pkg::SHARE_W-1:0]            share
);
    import wta_pkg::*;

    logic               busy_reg, busy_next;
    logic [3:0]         count_reg, count_next;
    logic [SHARE_W-1:0] dq_reg, dq_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W:0]     rem_shift;
    logic               take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        rem_shift  = {rem_reg, dq_reg[SHARE_W-1]};
        take       = rem_shift >= {1'b0, divisor};
        busy_next  = busy_reg;
        count_next = count_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = 4'(SHARE_W - 1);
            dq_next    = SHARE_W'(FRAC_ONE) + SHARE_W'(divisor >> 1);
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = take ? CNT_W'(rem_shift - {1'b0, divisor}) : CNT_W'(rem_shift);
            dq_next    = {dq_reg[SHARE_W-2:0], take};
            count_next = count_reg - 4'd1;
            if (count_reg == 4'd0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign done  = !busy_reg;
    assign share = dq_reg;

endmodule

`default_nettype wire

// ----- src/wta_upd.sv -----
// Shared multiply unit that moves one weight toward its target by the learning rate.
`default_nettype none

module wta_upd (
    input  wire logic                                 clk,
    input  wire logic                                 load,
    input  wire logic signed [wta_pkg::WEIGHT_BITS-1:0] w_in,
    input  wire logic                                 pixel_set,
    input  wire logic [wta_pkg::SHARE_W-1:0]          share,
    input  wire logic [wta_pkg::LR_W-1:0]             lr,
    output logic signed [wta_pkg::WEIGHT_BITS-1:0]    w_out
);
    import wta_pkg::*;

    localparam int DIFF_W = WEIGHT_BITS + 2;
    localparam int PROD_W = DIFF_W + LR_W + 1;
    localparam int STEP_W = PROD_W - 16;
    localparam int NEW_W  = STEP_W + 1;
    localparam logic signed [NEW_W-1:0] W_MAX = NEW_W'((64'sd1 <<< (WEIGHT_BITS - 1)) - 1);
    localparam logic signed [NEW_W-1:0] W_MIN = NEW_W'(-(64'sd1 <<< (WEIGHT_BITS - 1)));

    logic signed [DIFF_W-1:0]      target;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [PROD_W-1:0]      prod_next, prod_reg;
    logic signed [WEIGHT_BITS-1:0] w_reg;
    logic signed [PROD_W-1:0]      rounded;
    logic signed [STEP_W-1:0]      step;
    logic signed [NEW_W-1:0]       new_w;

    always_comb
    begin
        target    = pixel_set ? $signed({{(DIFF_W - SHARE_W){1'b0}}, share}) : '0;
        diff      = target - DIFF_W'(w_in);
        prod_next = $signed({1'b0, lr}) * diff;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
            w_reg    <= w_in;
        end
    end

    always_comb
    begin
        rounded = prod_reg + PROD_W'(32768);
        step    = rounded[PROD_W-1:16];
        new_w   = NEW_W'(w_reg) + NEW_W'(step);
        if (new_w > W_MAX)
        begin
            w_out = WEIGHT_BITS'(W_MAX);
        end
        else if (new_w < W_MIN)
        begin
            w_out = WEIGHT_BITS'(W_MIN);
        end
        else
        begin
            w_out = WEIGHT_BITS'(new_w);
        end
    end

endmodule

`default_nettype wire

// ----- src/winner_take_all_learning_layer.sv -----
// A weight load or ignored pixel beat is taken in ST_IDLE. A pixel beat that sets a new
// pixel reads and adds for each of the n neurons in use. A last pixel adds the winner pick
// over the n neurons, the divider, the report (held while an earlier result waits) and a read,
// multiply and write per input for the update; an empty pattern skips the divider and update.
// The result register lets a new beat enter while a result waits to be taken.
// Reset restores the default configuration and clears control and pattern state; weights stay
`default_nettype none

module winner_take_all_learning_layer (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write_en,
    input  wire logic [wta_pkg::CIDX_W-1:0]            cfg_index,
    input  wire logic [wta_pkg::CFG_W-1:0]             cfg_data,
    input  wire logic                                  item_valid,
    output logic                                       item_stall,
    input  wire logic                                  action,
    input  wire logic [wta_pkg::NSEL_W-1:0]            neuron_sel,
    input  wire logic [wta_pkg::POS_W-1:0]             position,
    input  wire logic signed [wta_pkg::WEIGHT_BITS-1:0] weight_value,
    input  wire logic                                  pixel,
    input  wire logic                                  last_pixel,
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output logic [wta_pkg::NSEL_W-1:0]                 winner,
    output logic signed [wta_pkg::ACC_W-1:0]           winner_activation,
    output logic                                       empty_input
);
    import wta_pkg::*;

    localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W+1)'((64'sd1 <<< (ACC_W - 1)) - 1);
    localparam logic signed [ACC_W:0] ACC_MIN = (ACC_W+1)'(-(64'sd1 <<< (ACC_W - 1)));

    state_t                  state_reg, state_next;
    logic [LR_W-1:0]         lr_reg;
    logic [NU_W-1:0]         nu_reg;
    logic [CNT_W-1:0]        iu_reg;
    logic [MAX_INPUTS-1:0]   pixel_reg, pixel_next;
    logic [CNT_W-1:0]        ones_count_reg, ones_count_next;
    logic signed [ACC_W-1:0] acc_reg [MAX_NEURONS];
    logic signed [ACC_W-1:0] acc_next [MAX_NEURONS];
    logic [NSEL_W-1:0]       j_reg, j_next;
    logic [POS_W-1:0]        k_reg, k_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    last_reg, last_next;
    logic [NSEL_W-1:0]       best_reg, best_next;
    logic signed [ACC_W-1:0] best_val_reg, best_val_next;
    logic                    result_valid_reg, result_valid_next;
    logic [NSEL_W-1:0]       winner_reg, winner_next;
    logic signed [ACC_W-1:0] act_reg, act_next;
    logic                    empty_reg, empty_next;

    logic [NU_W-1:0]         eff_n;
    logic [CNT_W-1:0]        eff_m;
    logic [NSEL_W-1:0]       last_neuron;
    logic [POS_W-1:0]        last_input;
    logic                    accept;
    logic signed [ACC_W:0]   acc_sum;
    wmem_wr_t                wr;
    logic [ADDR_W-1:0]       raddr;
    logic signed [WEIGHT_BITS-1:0] rdata;
    logic                    div_start;
    logic                    div_done;
    logic [SHARE_W-1:0]      share;
    logic                    upd_load;
    logic signed [WEIGHT_BITS-1:0] upd_w;

    wta_wmem u_wmem (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    wta_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (ones_count_reg),
        .done    (div_done),
        .share   (share)
    );

    wta_upd u_upd (
        .clk       (clk),
        .load      (upd_load),
        .w_in      (rdata),
        .pixel_set (pixel_reg[k_reg]),
        .share     (share),
        .lr        (lr_reg),
        .w_out     (upd_w)
    );

    always_comb
    begin
        if (nu_reg == '0)
        begin
            eff_n = NU_W'(1);
        end
        else if (nu_reg > NU_W'(MAX_NEURONS))
        begin
            eff_n = NU_W'(MAX_NEURONS);
        end
        else
        begin
            eff_n = nu_reg;
        end
        if (iu_reg == '0)
        begin
            eff_m = CNT_W'(1);
        end
        else if (iu_reg > CNT_W'(MAX_INPUTS))
        begin
            eff_m = CNT_W'(MAX_INPUTS);
        end
        else
        begin
            eff_m = iu_reg;
        end
        last_neuron = NSEL_W'(eff_n - NU_W'(1));
        last_input  = POS_W'(eff_m - CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg <= LR_RESET;
            nu_reg <= NEURONS_RESET;
            iu_reg <= INPUTS_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_LEARNING_RATE:  lr_reg <= cfg_data[LR_W-1:0];
                CFG_NEURONS_IN_USE: nu_reg <= cfg_data[NU_W-1:0];
                CFG_INPUTS_IN_USE:  iu_reg <= cfg_data[CNT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pixel_reg        <= '0;
            ones_count_reg   <= '0;
            for (int i = 0; i < MAX_NEURONS; i++)
            begin
                acc_reg[i] <= '0;
            end
            j_reg            <= '0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pixel_reg        <= pixel_next;
            ones_count_reg   <= ones_count_next;
            acc_reg          <= acc_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        last_reg     <= last_next;
        best_reg     <= best_next;
        best_val_reg <= best_val_next;
        winner_reg   <= winner_next;
        act_reg      <= act_next;
        empty_reg    <= empty_next;
    end

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        state_next        = state_reg;
        pixel_next        = pixel_reg;
        ones_count_next   = ones_count_reg;
        acc_next          = acc_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        pos_next          = pos_reg;
        last_next         = last_reg;
        best_next         = best_reg;
        best_val_next     = best_val_reg;
        winner_next       = winner_reg;
        act_next          = act_reg;
        empty_next        = empty_reg;
        result_valid_next = result_valid_reg && result_stall;
        wr                = '0;
        raddr             = {j_reg, pos_reg};
        div_start         = 1'b0;
        upd_load          = 1'b0;
        acc_sum           = (ACC_W+1)'(acc_reg[j_reg]) + (ACC_W+1)'(rdata);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_LOAD)
                    begin
                        wr.en   = 1'b1;
                        wr.addr = {neuron_sel, position};
                        wr.data = weight_value;
                    end
                    else
                    begin
                        pos_next  = position;
                        last_next = last_pixel;
                        j_next    = '0;
                        if (({1'b0, position} < eff_m) && pixel && !pixel_reg[position])
                        begin
                            pixel_next[position] = 1'b1;
                            ones_count_next      = ones_count_reg + CNT_W'(1);
                            state_next           = ST_ACC_RD;
                        end
                        else if (last_pixel)
                        begin
                            state_next = ST_PICK;
                        end
                    end
                end
            end

            ST_ACC_RD:
            begin
                state_next = ST_ACC_ADD;
            end

            ST_ACC_ADD:
            begin
                if (acc_sum > ACC_MAX)
                begin
                    acc_next[j_reg] = ACC_W'(ACC_MAX);
                end
                else if (acc_sum < ACC_MIN)
                begin
                    acc_next[j_reg] = ACC_W'(ACC_MIN);
                end
                else
                begin
                    acc_next[j_reg] = ACC_W'(acc_sum);
                end
                if (j_reg == last_neuron)
                begin
                    j_next     = '0;
                    state_next = last_reg ? ST_PICK : ST_IDLE;
                end
                else
                begin
                    j_next     = j_reg + NSEL_W'(1);
                    state_next = ST_ACC_RD;
                end
            end

            ST_PICK:
            begin
                if ((j_reg == '0) || (acc_reg[j_reg] >= best_val_reg))
                begin
                    best_next     = j_reg;
                    best_val_next = acc_reg[j_reg];
                end
                if (j_reg == last_neuron)
                begin
                    j_next = '0;
                    if (ones_count_reg != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_REPORT;
                    end
                end
                else
                begin
                    j_next = j_reg + NSEL_W'(1);
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_REPORT;
                end
            end

            ST_REPORT:
            begin
                if (!(result_valid_reg && result_stall))
                begin
                    result_valid_next = 1'b1;
                    winner_next       = best_reg;
                    act_next          = best_val_reg;
                    empty_next        = (ones_count_reg == '0);
                    k_next            = '0;
                    if (ones_count_reg != '0)
                    begin
                        state_next = ST_UPD_RD;
                    end
                    else
                    begin
                        pixel_next      = '0;
                        ones_count_next = '0;
                        for (int i = 0; i < MAX_NEURONS; i++)
                        begin
                            acc_next[i] = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_UPD_RD:
            begin
                raddr      = {best_reg, k_reg};
                state_next = ST_UPD_MUL;
            end

            ST_UPD_MUL:
            begin
                raddr      = {best_reg, k_reg};
                upd_load   = 1'b1;
                state_next = ST_UPD_WR;
            end

            ST_UPD_WR:
            begin
                raddr   = {best_reg, k_reg};
                wr.en   = 1'b1;
                wr.addr = {best_reg, k_reg};
                wr.data = upd_w;
                if (k_reg == last_input)
                begin
                    k_next          = '0;
                    pixel_next      = '0;
                    ones_count_next = '0;
                    for (int i = 0; i < MAX_NEURONS; i++)
                    begin
                        acc_next[i] = '0;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + POS_W'(1);
                    state_next = ST_UPD_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid      = result_valid_reg;
    assign winner            = winner_reg;
    assign winner_activation = act_reg;
    assign empty_input       = empty_reg;

`ifndef ASSERT_OFF
    a_ones_match : assert property (@(posedge clk) disable iff (!rst_n)
        ones_count_reg == CNT_W'($countones(pixel_reg)))
        else $error("set pixel count does not match the pixel store");

    a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && empty_input) |-> (winner_activation == '0))
        else $error("empty pattern reported a nonzero activation");

    a_load_ready : assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (action == ACT_LOAD)) |=> !item_stall)
        else $error("block stalled after a weight load beat");
`endif

endmodule

`default_nettype wire
